FILE: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical frame bitmap allocator package
// Sizes, operation codes, controller states, command and status bundles, and
// the helper functions for each bitmap word's reset and range masks and lowest set bit.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Memory geometry.
  localparam int NUM_FRAMES      = 16384;
  localparam int RESERVED_FRAMES = 2048;
  localparam int FRAME_BYTES     = 4096;

  // Field widths of the request and result items.
  localparam int OP_W   = 2;
  localparam int ADDR_W = 26;
  localparam int FREE_W = 15;

  // Derived sizes.
  localparam int BOUNDARY   = (RESERVED_FRAMES < NUM_FRAMES) ? RESERVED_FRAMES : NUM_FRAMES;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = 6;
  localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FB_SHIFT   = $clog2(FRAME_BYTES);
  localparam int FRAME_IN_W = ADDR_W - FB_SHIFT;
  localparam int COUNT_W    = $clog2(NUM_FRAMES + 1);
  localparam int START_WORD = BOUNDARY / WORD_BITS;
  localparam int FREE_INIT  = NUM_FRAMES - BOUNDARY;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FREE_WR,
    ST_RESP
  } pfba_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic rd_start;
    logic rd_next;
    logic set_bit;
    logic clr_bit;
    logic set_ok;
    logic load_out;
  } pfba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            range_ok;
    logic            free_zero;
    logic            hit;
    logic            last_word;
    logic            out_free;
  } pfba_sts_t;

  // Value of a bitmap word after reset: reserved frames are marked used.
  function automatic map_word_t reset_word(input logic [WORD_W-1:0] w);
    map_word_t res;
    int        f;
    res = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = int'(w) * WORD_BITS + b;
      res[b] = (f < BOUNDARY);
    end
    return res;
  endfunction

  // Bits of a bitmap word that belong to allocatable frames.
  function automatic map_word_t alloc_mask(input logic [WORD_W-1:0] w);
    map_word_t res;
    int        f;
    res = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = int'(w) * WORD_BITS + b;
      res[b] = (f >= BOUNDARY) && (f < NUM_FRAMES);
    end
    return res;
  endfunction

  // Index of the lowest set bit of a word.
  function automatic logic [BIT_W-1:0] lowest_set(input map_word_t v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/pfba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical frame bitmap allocator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------

// Request channel: operation and byte address of a frame to free.
interface pfba_req_if import pfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] frame_address;

  modport source (output valid, output operation, output frame_address, input ready);
  modport sink   (input valid, input operation, input frame_address, output ready);
endinterface

// Result channel: allocated address, success flag and free frame count.
interface pfba_rsp_if import pfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              success;
  logic [FREE_W-1:0] free_frames;

  modport source (output valid, output address, output success, output free_frames,
                  input ready);
  modport sink   (input valid, input address, input success, input free_frames,
                  output ready);
endinterface

FILE: rtl/pfba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical frame bitmap allocator controller
// Sequences one request item at a time: accept, dispatch, bitmap scan or
// read-modify-write, and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module pfba_ctrl import pfba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output pfba_cmd_t cmd_o,
  input  pfba_sts_t sts_i
);

  pfba_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_req = 1'b1;
          state_nxt      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.op == OP_ALLOC) begin
          // An empty counter means no clear bit is left in range.
          if (sts_i.free_zero) begin
            state_nxt = ST_RESP;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end else if (sts_i.op == OP_FREE) begin
          if (sts_i.range_ok) begin
            cmd_o.rd_start = 1'b1;
            state_nxt      = ST_FREE_WR;
          end else begin
            state_nxt = ST_RESP;
          end
        end else if (sts_i.op == OP_COUNT) begin
          cmd_o.set_ok = 1'b1;
          state_nxt    = ST_RESP;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_SCAN: begin
        // Check the word read last cycle while fetching the next one.
        if (sts_i.hit) begin
          cmd_o.set_bit = 1'b1;
          state_nxt     = ST_RESP;
        end else if (sts_i.last_word) begin
          state_nxt = ST_RESP;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      ST_FREE_WR: begin
        cmd_o.clr_bit = 1'b1;
        state_nxt     = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A frame is only marked when the checked word really has a free bit.
  a_set_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.set_bit |-> sts_i.hit)
    else $error("frame marked without a free bit in the word");

  // A result is never written over one that is still waiting.
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result register overwritten");

  // A scan only runs while the counter reports free frames.
  a_scan_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !sts_i.free_zero)
    else $error("scan running with no free frames");

endmodule

FILE: rtl/pfba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical frame bitmap allocator datapath
// Holds the bitmap memory with per-word valid bits, the free frame counter,
// the request registers and the result output register.
// ----------------------------------------------------------------------------
module pfba_dp import pfba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pfba_cmd_t         cmd_i,
  output pfba_sts_t         sts_o,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ADDR_W-1:0] in_frame_address,
  pfba_rsp_if.source        out_chan
);

  // Bitmap storage.
  map_word_t               mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]    vld_r;
  map_word_t               rdata_r;
  logic                    rd_vld_r;
  logic [WORD_W-1:0]       rd_word_r;
  logic [WORD_W-1:0]       scan_addr_r;

  // Request and result registers.
  logic [OP_W-1:0]         op_r;
  logic [FRAME_IN_W-1:0]   frame_r;
  logic [COUNT_W-1:0]      free_total_r;
  logic [ADDR_W-1:0]       res_addr_r;
  logic                    res_ok_r;
  logic                    out_valid_r;
  logic [ADDR_W-1:0]       out_addr_r;
  logic                    out_ok_r;
  logic [FREE_W-1:0]       out_free_r;

  logic [WORD_W-1:0]       frame_word;
  logic [WORD_W-1:0]       rd_addr;
  logic                    rd_en;
  map_word_t               word_q;
  map_word_t               avail;
  logic [BIT_W-1:0]        found_idx;
  logic [BIT_W-1:0]        free_idx;
  logic                    wr_en;
  map_word_t               wr_data;
  logic [WORD_W+BIT_W+FB_SHIFT-1:0] found_byte;

  // Read address: first word of the scan, the word of a freed frame, or the
  // next word of a running scan.
  assign frame_word = WORD_W'(frame_r >> BIT_W);
  assign free_idx   = frame_r[BIT_W-1:0];
  always_comb begin
    if (cmd_i.rd_start) begin
      rd_addr = (op_r == OP_FREE) ? frame_word : WORD_W'(START_WORD);
    end else begin
      rd_addr = scan_addr_r;
    end
  end
  assign rd_en = cmd_i.rd_start | cmd_i.rd_next;

  // A word never written since reset reads as its reset value.
  assign word_q     = rd_vld_r ? rdata_r : reset_word(rd_word_r);
  assign avail      = ~word_q & alloc_mask(rd_word_r);
  assign found_idx  = lowest_set(avail);
  assign found_byte = {rd_word_r, found_idx, {FB_SHIFT{1'b0}}};

  // Write back the word with the found bit set or the freed bit cleared.
  assign wr_en = cmd_i.set_bit | cmd_i.clr_bit;
  always_comb begin
    if (cmd_i.set_bit) begin
      wr_data = word_q | (map_word_t'(1) << found_idx);
    end else begin
      wr_data = word_q & ~(map_word_t'(1) << free_idx);
    end
  end

  // Bitmap memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_word_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Read bookkeeping.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r    <= vld_r[rd_addr];
      rd_word_r   <= rd_addr;
      scan_addr_r <= rd_addr + 1'b1;
    end
  end

  // Per-word valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[rd_word_r] <= 1'b1;
    end
  end

  // Free frame counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_total_r <= COUNT_W'(FREE_INIT);
    end else if (cmd_i.set_bit) begin
      free_total_r <= free_total_r - 1'b1;
    end else if (cmd_i.clr_bit && word_q[free_idx]) begin
      free_total_r <= free_total_r + 1'b1;
    end
  end

  // Request capture and result building.
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      op_r       <= in_operation;
      frame_r    <= FRAME_IN_W'(in_frame_address >> FB_SHIFT);
      res_addr_r <= '0;
      res_ok_r   <= 1'b0;
    end else if (cmd_i.set_bit) begin
      res_addr_r <= ADDR_W'(found_byte);
      res_ok_r   <= 1'b1;
    end else if (cmd_i.clr_bit || cmd_i.set_ok) begin
      res_ok_r <= 1'b1;
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_addr_r <= res_addr_r;
      out_ok_r   <= res_ok_r;
      out_free_r <= FREE_W'(free_total_r);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.address     = out_addr_r;
  assign out_chan.success     = out_ok_r;
  assign out_chan.free_frames = out_free_r;

  // Status toward the controller.
  assign sts_o.op        = op_r;
  assign sts_o.range_ok  = (32'(frame_r) >= 32'(BOUNDARY)) && (32'(frame_r) < 32'(NUM_FRAMES));
  assign sts_o.free_zero = (free_total_r == '0);
  assign sts_o.hit       = |avail;
  assign sts_o.last_word = (rd_word_r == WORD_W'(MAP_WORDS - 1));
  assign sts_o.out_free  = !out_valid_r || out_chan.ready;

  // The counter never exceeds the number of allocatable frames.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= COUNT_W'(FREE_INIT))
    else $error("free frame counter above allocatable range");

  // Marking a frame takes exactly one off the counter.
  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.set_bit |=> free_total_r == $past(free_total_r) - 1'b1)
    else $error("counter not decremented on allocation");

endmodule

FILE: rtl/physical_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Physical frame bitmap allocator
// First-fit frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  in_chan   input      valid / ready    operation, frame_address
//  out_chan  output     valid / ready    address, success, free_frames
//
//  One item is in work at a time. Allocate scans the bitmap from the first
//  allocatable word, one 64-bit word per cycle from the single memory read
//  port (up to 224 words here). Free rewrites its frame's word when the frame
//  is allocatable; count and unknown codes touch no word. Reset clears the
//  per-word valid bits at once, so no clearing pass runs. A waiting result
//  sits in the output register while the next item is accepted; a stalled
//  sink holds the block at result hand-off.
// ----------------------------------------------------------------------------
module physical_frame_bitmap_allocator import pfba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  pfba_req_if.sink   in_chan,
  pfba_rsp_if.source out_chan
);

  pfba_cmd_t cmd;
  pfba_sts_t sts;
  logic      in_ready;

  assign in_chan.ready = in_ready;

  // Sequencer.
  pfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // Bitmap, counter and result registers.
  pfba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_operation     (in_chan.operation),
    .in_frame_address (in_chan.frame_address),
    .out_chan         (out_chan)
  );

endmodule
